>>> src/abbt_pkg.sv
// Shared widths, register codes and structures of the alpha bounding box tracker.
package abbt_pkg;

  localparam int DIM_W       = 13;
  localparam int ALPHA_W     = 8;
  localparam int OFS_W       = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 80;
  localparam int DIM_RESET   = 64;
  localparam int THR_RESET   = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_MODE      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               restart;
    logic [DIM_W-1:0]   start_w;
    logic [DIM_W-1:0]   start_h;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [ALPHA_W-1:0] threshold;
  } scan_ctl_t;

  typedef struct packed {
    logic [DIM_W-1:0] min_x;
    logic [DIM_W-1:0] min_y;
    logic [DIM_W-1:0] end_x;
    logic [DIM_W-1:0] end_y;
  } box_t;

  typedef struct packed {
    logic load;
    box_t box;
  } frame_t;

  // First member lands in the highest bits, so min_x sits at bit 0.
  typedef struct packed {
    logic [OFS_W-1:0] ofs_y2;
    logic [OFS_W-1:0] ofs_x2;
    logic [DIM_W-1:0] end_y;
    logic [DIM_W-1:0] end_x;
    logic [DIM_W-1:0] min_y;
    logic [DIM_W-1:0] min_x;
  } result_t;

endpackage

>>> src/abbt_scan.sv
// Input register, raster counters and running opaque box.
module abbt_scan #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  abbt_pkg::scan_ctl_t           ctl,
  input  logic                          in_valid,
  input  logic [abbt_pkg::ALPHA_W-1:0]  in_alpha,
  output logic                          in_ready,
  input  logic                          out_busy,
  output abbt_pkg::frame_t              frame
);

  localparam int DIM_W = abbt_pkg::DIM_W;
  localparam int CNT_W = (MAX_DIMENSION > 8192) ? DIM_W : $clog2(MAX_DIMENSION);
  localparam logic [DIM_W-1:0] RESET_DIM = (abbt_pkg::DIM_RESET > MAX_DIMENSION) ?
                                           DIM_W'(MAX_DIMENSION) :
                                           DIM_W'(abbt_pkg::DIM_RESET);

  logic                         a_valid;
  logic [abbt_pkg::ALPHA_W-1:0] a_alpha;
  logic [CNT_W-1:0]             col;
  logic [CNT_W-1:0]             row;
  logic [DIM_W-1:0]             min_x;
  logic [DIM_W-1:0]             min_y;
  logic [CNT_W-1:0]             max_x;
  logic [CNT_W-1:0]             max_y;

  logic [DIM_W:0]   col_inc;
  logic [DIM_W:0]   row_inc;
  logic             col_end;
  logic             row_end;
  logic             a_last;
  logic             opaque;
  logic             adv;
  logic [DIM_W-1:0] col_d;
  logic [DIM_W-1:0] row_d;
  logic [DIM_W-1:0] min_x_upd;
  logic [DIM_W-1:0] min_y_upd;
  logic [CNT_W-1:0] max_x_upd;
  logic [CNT_W-1:0] max_y_upd;

  always_comb begin
    col_inc = (DIM_W+1)'(col) + 1'b1;
    row_inc = (DIM_W+1)'(row) + 1'b1;
    col_end = col_inc >= (DIM_W+1)'(ctl.w);
    row_end = row_inc >= (DIM_W+1)'(ctl.h);
    a_last  = col_end && row_end;
    opaque  = a_alpha > ctl.threshold;
    col_d   = DIM_W'(col);
    row_d   = DIM_W'(row);

    min_x_upd = (opaque && (col_d < min_x)) ? col_d : min_x;
    min_y_upd = (opaque && (row_d < min_y)) ? row_d : min_y;
    max_x_upd = (opaque && (col > max_x)) ? col : max_x;
    max_y_upd = (opaque && (row > max_y)) ? row : max_y;

    // A frame's last pixel waits only while the previous result is still held.
    adv      = a_valid && (!a_last || !out_busy);
    in_ready = !a_valid || adv;

    frame.load      = adv && a_last;
    frame.box.min_x = min_x_upd;
    frame.box.min_y = min_y_upd;
    frame.box.end_x = DIM_W'(max_x_upd) + 1'b1;
    frame.box.end_y = DIM_W'(max_y_upd) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_alpha <= in_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      col     <= '0;
      row     <= '0;
      min_x   <= RESET_DIM;
      min_y   <= RESET_DIM;
      max_x   <= '0;
      max_y   <= '0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (ctl.restart) begin
        col   <= '0;
        row   <= '0;
        min_x <= ctl.start_w;
        min_y <= ctl.start_h;
        max_x <= '0;
        max_y <= '0;
      end else if (adv) begin
        if (a_last) begin
          col   <= '0;
          row   <= '0;
          min_x <= ctl.start_w;
          min_y <= ctl.start_h;
          max_x <= '0;
          max_y <= '0;
        end else begin
          col   <= col_end ? '0 : col_inc[CNT_W-1:0];
          row   <= col_end ? row_inc[CNT_W-1:0] : row;
          min_x <= min_x_upd;
          min_y <= min_y_upd;
          max_x <= max_x_upd;
          max_y <= max_y_upd;
        end
      end
    end
  end

endmodule

>>> src/abbt_out.sv
// Result formatting and output register.
module abbt_out (
  input  logic                              clk,
  input  logic                              rst,
  input  abbt_pkg::frame_t                  frame,
  input  logic                              mode,
  input  logic [abbt_pkg::DIM_W-1:0]        w,
  input  logic [abbt_pkg::DIM_W-1:0]        h,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [abbt_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                              out_busy
);

  localparam int OFS_W = abbt_pkg::OFS_W;

  abbt_pkg::result_t res;
  abbt_pkg::result_t res_reg;
  logic              valid;

  always_comb begin
    if (mode) begin
      res.min_x  = frame.box.min_x;
      res.min_y  = frame.box.min_y;
      res.end_x  = frame.box.end_x;
      res.end_y  = frame.box.end_y;
      res.ofs_x2 = OFS_W'(frame.box.min_x) + OFS_W'(frame.box.end_x) - OFS_W'(w);
      res.ofs_y2 = OFS_W'(h) - OFS_W'(frame.box.min_y) - OFS_W'(frame.box.end_y);
    end else begin
      res.min_x  = '0;
      res.min_y  = '0;
      res.end_x  = w;
      res.end_y  = h;
      res.ofs_x2 = '0;
      res.ofs_y2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.load) begin
      res_reg <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (frame.load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = res_reg;
  assign out_busy = valid && !m_tready;

endmodule

>>> src/alpha_bounding_box_tracker_core.sv
// Top level of the alpha bounding box tracker: configuration registers and datapath wiring.

// The core takes one alpha byte per clock in raster order and sustains one pixel
// transfer per cycle; each pixel passes an input register, the counter and box
// update logic, and, on the last pixel of a frame, the result register, so a
// result is offered from the result register once its last pixel has left the
// input register, and can be taken at the following clock edge. The only place
// that holds the stream is the single result register: while a result waits to
// be taken, pixels of the next frame keep flowing, and only that frame's last
// pixel waits in the input register until the result has gone. Width and height
// are used clamped to 1..MAX_DIMENSION; writing either one restarts the frame.
// Threshold and mode are used as they stand when a pixel is processed, and the
// mode in force at a frame's last pixel decides whether the tracked box or the
// full image box is reported. An empty frame reports the image size as its
// minimum corner and one as its end. Configuration should be written while no
// pixel is in flight.
module alpha_bounding_box_tracker_core #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [abbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [abbt_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Pixel stream. tdata: pixel_alpha[7:0].
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [abbt_pkg::IN_TDATA_W-1:0]    s_tdata,
  // Result stream. tdata from bit 0: box_min_x[12:0], box_min_y[25:13],
  // box_end_x[38:26], box_end_y[51:39], center_offset_x2[65:52],
  // center_offset_y2[79:66].
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [abbt_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int DIM_W = abbt_pkg::DIM_W;
  localparam logic [31:0] MAX_U = 32'(MAX_DIMENSION);

  // Clamp a programmed size into the legal range; zero counts as one.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_U) begin
      r = MAX_U[DIM_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [DIM_W-1:0]             width_reg;
  logic [DIM_W-1:0]             height_reg;
  logic [abbt_pkg::ALPHA_W-1:0] threshold_reg;
  logic                         mode_reg;

  logic                         wr_width;
  logic                         wr_height;
  abbt_pkg::scan_ctl_t          ctl;
  abbt_pkg::frame_t             frame;
  logic                         out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg     <= DIM_W'(abbt_pkg::DIM_RESET);
      height_reg    <= DIM_W'(abbt_pkg::DIM_RESET);
      threshold_reg <= abbt_pkg::ALPHA_W'(abbt_pkg::THR_RESET);
      mode_reg      <= 1'b1;
    end else if (cfg_we) begin
      unique case (abbt_pkg::cfg_reg_t'(cfg_index))
        abbt_pkg::REG_WIDTH:     width_reg     <= cfg_data;
        abbt_pkg::REG_HEIGHT:    height_reg    <= cfg_data;
        abbt_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[abbt_pkg::ALPHA_W-1:0];
        abbt_pkg::REG_MODE:      mode_reg      <= cfg_data[0];
      endcase
    end
  end

  // A size write restarts the frame; the new running minimum must already see
  // the clamped value being written, so it is taken from the write data.
  always_comb begin
    wr_width      = cfg_we && (cfg_index == abbt_pkg::REG_WIDTH);
    wr_height     = cfg_we && (cfg_index == abbt_pkg::REG_HEIGHT);
    ctl.w         = clamp_dim(width_reg);
    ctl.h         = clamp_dim(height_reg);
    ctl.restart   = wr_width || wr_height;
    ctl.start_w   = wr_width ? clamp_dim(cfg_data) : ctl.w;
    ctl.start_h   = wr_height ? clamp_dim(cfg_data) : ctl.h;
    ctl.threshold = threshold_reg;
  end

  abbt_scan #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .in_valid (s_tvalid),
    .in_alpha (s_tdata[abbt_pkg::ALPHA_W-1:0]),
    .in_ready (s_tready),
    .out_busy (out_busy),
    .frame    (frame)
  );

  abbt_out u_out (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame),
    .mode     (mode_reg),
    .w        (ctl.w),
    .h        (ctl.h),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .out_busy (out_busy)
  );

endmodule

>>> src/abbt_checker.sv
// Port-level checks of the alpha bounding box tracker and their binding.
module abbt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [abbt_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // The pixel side is held back only while a result waits to be taken.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("pixel input stalled without a stalled result");

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed or vanished");

endmodule

bind alpha_bounding_box_tracker_core abbt_checker u_abbt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
